>>> design/zbp_pkg.sv
// shared types, constants and codes for the z-buffer point plotter
`default_nettype none
package zbp_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 64;
	localparam int PIX_COUNT  = MAX_WIDTH * MAX_HEIGHT;

	localparam int ADDR_W  = $clog2(PIX_COUNT);
	localparam int CNT_W   = $clog2(PIX_COUNT + 1);
	localparam int EW_W    = $clog2(MAX_WIDTH + 1);
	localparam int EH_W    = $clog2(MAX_HEIGHT + 1);
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int POS_W   = 20;
	localparam int DEPTH_W = 22;

	// kind codes, anything else reads a pixel
	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_POINT = 2'd1;

	// register indexes
	localparam logic [2:0] CFG_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_ASPECT = 3'd2;
	localparam logic [2:0] CFG_CAM_X  = 3'd3;
	localparam logic [2:0] CFG_CAM_Y  = 3'd4;
	localparam logic [2:0] CFG_CAM_Z  = 3'd5;

	typedef enum logic [2:0] {
		ST_DRAWN   = 3'd0,
		ST_BEHIND  = 3'd1,
		ST_OFF     = 3'd2,
		ST_HIDDEN  = 3'd3,
		ST_CLEARED = 3'd4,
		ST_READ    = 3'd5
	} status_t;

	// one pixel entry: color, glyph and depth side by side
	typedef struct packed {
		logic [7:0]                color;
		logic [7:0]                glyph;
		logic signed [DEPTH_W-1:0] depth;
	} pix_t;

	// mapped point handed from the mapper to the controller
	typedef struct packed {
		logic                      valid;
		logic                      behind;
		logic                      off;
		logic [ADDR_W-1:0]         offset;
		logic signed [DEPTH_W-1:0] depth;
	} map_res_t;

endpackage
`default_nettype wire

>>> design/zbp_mem.sv
// pixel memory: one write port, one read port with registered data
`default_nettype none
module zbp_mem
	import zbp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire pix_t              wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output pix_t                   rdata
);

	pix_t mem_q [PIX_COUNT];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> design/zbp_map.sv
// four-stage pipeline mapping a point to a pixel offset and a depth
`default_nettype none
module zbp_map
	import zbp_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_v,
	input  wire logic signed [POS_W-1:0] pos_x,
	input  wire logic signed [POS_W-1:0] pos_y,
	input  wire logic signed [POS_W-1:0] pos_z,
	input  wire logic signed [POS_W-1:0] depth_bias,
	input  wire logic signed [POS_W-1:0] cam_x,
	input  wire logic signed [POS_W-1:0] cam_y,
	input  wire logic signed [POS_W-1:0] cam_z,
	input  wire logic [15:0]             aspect,
	input  wire logic [EW_W-1:0]         w_eff,
	input  wire logic [EH_W-1:0]         h_eff,
	output map_res_t                     res
);

	localparam logic signed [21:0] HALF_X = 22'sd4096;
	localparam logic signed [38:0] HALF_Y = 39'sd16777216;

	// stage 1: camera-relative coordinates
	logic                      v_s1, behind_s1;
	logic signed [21:0]        dx4_s1;
	logic signed [20:0]        dy_s1;
	logic signed [DEPTH_W-1:0] depth_s1;
	// stage 2: products
	logic                      v_s2, behind_s2;
	logic signed [30:0]        nx_s2;
	logic signed [37:0]        py_s2;
	logic signed [DEPTH_W-1:0] depth_s2;
	// stage 3: column settled, row product
	logic                      v_s3, behind_s3, offx_s3;
	logic [COL_W-1:0]          col_s3;
	logic signed [46:0]        ny_s3;
	logic signed [DEPTH_W-1:0] depth_s3;
	// stage 4: mapped point
	logic                      v_s4, behind_s4, off_s4;
	logic [ADDR_W-1:0]         offset_s4;
	logic signed [DEPTH_W-1:0] depth_s4;

	logic signed [20:0]        dz;
	logic signed [38:0]        py2;
	logic [16:0]               col_full;
	logic [20:0]               row_full;
	logic [ROW_W-1:0]          row;
	logic                      offy;
	logic [ROW_W+EW_W-1:0]     lin;

	assign dz       = 21'(pos_z) - 21'(cam_z);
	assign py2      = {py_s2[37], py_s2} + HALF_Y;
	assign col_full = nx_s2[29:13];
	assign row_full = ny_s3[45:25];
	assign row      = ny_s3[ROW_W+24:25];
	assign offy     = ny_s3[46] || (row_full >= 21'(h_eff));
	assign lin      = (ROW_W+EW_W)'(row) * (ROW_W+EW_W)'(w_eff) + (ROW_W+EW_W)'(col_s3);

	assign res = '{valid: v_s4, behind: behind_s4, off: off_s4, offset: offset_s4,
		depth: depth_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		dx4_s1    <= 22'(pos_x) - 22'(cam_x) + HALF_X;
		dy_s1     <= 21'(pos_y) - 21'(cam_y);
		behind_s1 <= dz[20];
		depth_s1  <= DEPTH_W'(dz) + DEPTH_W'(depth_bias);

		nx_s2     <= $signed({1'b0, w_eff}) * dx4_s1;
		py_s2     <= dy_s1 * $signed({1'b0, aspect});
		behind_s2 <= behind_s1;
		depth_s2  <= depth_s1;

		offx_s3   <= nx_s2[30] || (col_full >= 17'(w_eff));
		col_s3    <= nx_s2[COL_W+12:13];
		ny_s3     <= $signed({1'b0, h_eff}) * py2;
		behind_s3 <= behind_s2;
		depth_s3  <= depth_s2;

		behind_s4 <= behind_s3;
		off_s4    <= offx_s3 || offy;
		offset_s4 <= lin[ADDR_W-1:0];
		depth_s4  <= depth_s3;
	end

endmodule
`default_nettype wire

>>> design/zbuffer_point_plotter_top.sv
// top level: registers, controller and pixel memory of the point plotter
// steps: point through 4 mapping stages, memory read, test and write, or
//   culled after mapping; read is lookup and test; clear one pixel a cycle
// throughput: one item at a time, set by the single read-modify-write path
//   through the pixel memory; a new item may start in the cycle done is high
// reset: registers take their defaults, then a clearing pass zeroes all
//   8192 pixels with busy high; config writes still taken
// the receiver cannot stall: done is a one-cycle strobe
`default_nettype none
module zbuffer_point_plotter_top
	import zbp_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// item channel
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [1:0]                kind,
	input  wire logic signed [POS_W-1:0]   pos_x,
	input  wire logic signed [POS_W-1:0]   pos_y,
	input  wire logic signed [POS_W-1:0]   pos_z,
	input  wire logic signed [POS_W-1:0]   depth_bias,
	input  wire logic [7:0]                glyph,
	input  wire logic [7:0]                color,
	input  wire logic signed [DEPTH_W-1:0] clear_depth,
	input  wire logic [12:0]               pixel_index,
	// result channel
	output logic                           done,
	output logic [2:0]                     status,
	output logic [12:0]                    pixel_out,
	output logic [7:0]                     read_glyph,
	output logic [7:0]                     read_color,
	// configuration write channel
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [2:0]                cfg_index,
	input  wire logic [19:0]               cfg_data
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_CLEAR,
		S_MAP,
		S_LOOKUP,
		S_TEST
	} state_t;

	// configuration registers
	logic [7:0]              scr_w_q;
	logic [6:0]              scr_h_q;
	logic [15:0]             aspect_q;
	logic signed [POS_W-1:0] cam_x_q, cam_y_q, cam_z_q;

	// controller state
	state_t                    state_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [CNT_W-1:0]          clear_n_q;
	logic                      is_point_q;
	logic [ADDR_W-1:0]         addr_q;
	logic [7:0]                glyph_q, color_q;
	logic signed [DEPTH_W-1:0] depth_q;

	// effective screen size, clamped to the store
	logic [EW_W-1:0]      w_eff;
	logic [EH_W-1:0]      h_eff;
	logic [EW_W+EH_W-1:0] area;

	map_res_t mres;
	logic     map_go;

	// memory ports
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	pix_t              mem_wdata;
	pix_t              mem_rdata;

	logic accept;
	logic pass;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign map_go    = accept && (kind == KIND_POINT);

	always_comb begin
		if (int'(scr_w_q) > MAX_WIDTH) begin
			w_eff = EW_W'(MAX_WIDTH);
		end else begin
			w_eff = EW_W'(scr_w_q);
		end
		if (int'(scr_h_q) > MAX_HEIGHT) begin
			h_eff = EH_W'(MAX_HEIGHT);
		end else begin
			h_eff = EH_W'(scr_h_q);
		end
		area = (EW_W+EH_W)'(w_eff) * (EW_W+EH_W)'(h_eff);
	end

	// config registers, taken whenever written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q  <= 8'd128;
			scr_h_q  <= 7'd64;
			aspect_q <= 16'd4096;
			cam_x_q  <= '0;
			cam_y_q  <= '0;
			cam_z_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WIDTH:  scr_w_q  <= cfg_data[7:0];
				CFG_HEIGHT: scr_h_q  <= cfg_data[6:0];
				CFG_ASPECT: aspect_q <= cfg_data[15:0];
				CFG_CAM_X:  cam_x_q  <= cfg_data;
				CFG_CAM_Y:  cam_y_q  <= cfg_data;
				CFG_CAM_Z:  cam_z_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// point mapping pipeline
	zbp_map u_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_v       (map_go),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.depth_bias (depth_bias),
		.cam_x      (cam_x_q),
		.cam_y      (cam_y_q),
		.cam_z      (cam_z_q),
		.aspect     (aspect_q),
		.w_eff      (w_eff),
		.h_eff      (h_eff),
		.res        (mres)
	);

	// less-or-equal depth test against the stored depth
	assign pass = (depth_q <= mem_rdata.depth);

	// memory write selection: reset sweep, clear sweep or a passing point
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q[ADDR_W-1:0];
		mem_wdata = '0;
		case (state_q)
			S_INIT: begin
				mem_we = 1'b1;
			end
			S_CLEAR: begin
				mem_we    = (cnt_q != clear_n_q);
				mem_wdata = '{color: color_q, glyph: glyph_q, depth: depth_q};
			end
			S_TEST: begin
				mem_we    = is_point_q && pass;
				mem_waddr = addr_q;
				mem_wdata = '{color: color_q, glyph: glyph_q, depth: depth_q};
			end
			default: ;
		endcase
	end

	zbp_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (addr_q),
		.rdata (mem_rdata)
	);

	// controller with registered result outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			cnt_q      <= '0;
			clear_n_q  <= '0;
			is_point_q <= 1'b0;
			addr_q     <= '0;
			glyph_q    <= '0;
			color_q    <= '0;
			depth_q    <= '0;
			done       <= 1'b0;
			status     <= ST_DRAWN;
			pixel_out  <= '0;
			read_glyph <= '0;
			read_color <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(PIX_COUNT - 1)) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						glyph_q <= glyph;
						color_q <= color;
						case (kind)
							KIND_CLEAR: begin
								depth_q   <= clear_depth;
								cnt_q     <= '0;
								clear_n_q <= area[CNT_W-1:0];
								state_q   <= S_CLEAR;
							end
							KIND_POINT: begin
								is_point_q <= 1'b1;
								state_q    <= S_MAP;
							end
							default: begin
								is_point_q <= 1'b0;
								addr_q     <= pixel_index[ADDR_W-1:0];
								state_q    <= S_LOOKUP;
							end
						endcase
					end
				end
				S_CLEAR: begin
					if (cnt_q == clear_n_q) begin
						done       <= 1'b1;
						status     <= ST_CLEARED;
						pixel_out  <= '0;
						read_glyph <= '0;
						read_color <= '0;
						state_q    <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_MAP: begin
					if (mres.valid) begin
						if (mres.behind || mres.off) begin
							done       <= 1'b1;
							status     <= mres.behind ? ST_BEHIND : ST_OFF;
							pixel_out  <= '0;
							read_glyph <= '0;
							read_color <= '0;
							state_q    <= S_IDLE;
						end else begin
							addr_q  <= mres.offset;
							depth_q <= mres.depth;
							state_q <= S_LOOKUP;
						end
					end
				end
				S_LOOKUP: begin
					// read of addr_q issued this cycle
					state_q <= S_TEST;
				end
				S_TEST: begin
					done      <= 1'b1;
					pixel_out <= 13'(addr_q);
					if (is_point_q) begin
						status     <= pass ? ST_DRAWN : ST_HIDDEN;
						read_glyph <= '0;
						read_color <= '0;
					end else begin
						status     <= ST_READ;
						read_glyph <= mem_rdata.glyph;
						read_color <= mem_rdata.color;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// an accepted item always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted item did not raise busy");

	// a result only ever closes out work in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item in flight");

	// results are never back to back, one per item
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	// the pixel memory is never written while idle
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("memory write while idle");

endmodule
`default_nettype wire

>>> verif/zbuffer_point_plotter_tb.sv
// self-checking testbench for the z-buffer point plotter: directed cases, then randomized phases
`timescale 1ns / 100ps
module testbench;
	import zbp_pkg::*;

	// kind codes past the two that the package names; both read a pixel
	localparam logic [1:0] KIND_READ  = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	// half a clip unit added before the column and row scaling
	localparam longint HALF_COL  = 64'sd4096;
	localparam longint HALF_ROW  = 64'sd16777216;
	localparam int     COL_SHIFT = 13;
	localparam int     ROW_SHIFT = 25;

	localparam int RANDOM_ITEMS = 1625;
	localparam int PHASES       = 8;
	localparam int MAX_REPORTS  = 10;
	localparam int TAIL_CYCLES  = 16;

	// one item as the sender sees it
	typedef struct {
		logic [1:0]                kind;
		logic signed [POS_W-1:0]   pos_x;
		logic signed [POS_W-1:0]   pos_y;
		logic signed [POS_W-1:0]   pos_z;
		logic signed [POS_W-1:0]   depth_bias;
		logic [7:0]                glyph;
		logic [7:0]                color;
		logic signed [DEPTH_W-1:0] clear_depth;
		logic [12:0]               pixel_index;
	} plot_item_t;

	// one result as it leaves the block
	typedef struct packed {
		status_t     status;
		logic [12:0] pixel;
		logic [7:0]  glyph;
		logic [7:0]  color;
	} pixel_result_t;

	// clock, reset and every block input start at known values
	logic                      clk;
	logic                      arst_n      = 1'b0;
	logic                      start       = 1'b0;
	logic                      busy;
	logic [1:0]                kind        = '0;
	logic signed [POS_W-1:0]   pos_x       = '0;
	logic signed [POS_W-1:0]   pos_y       = '0;
	logic signed [POS_W-1:0]   pos_z       = '0;
	logic signed [POS_W-1:0]   depth_bias  = '0;
	logic [7:0]                glyph       = '0;
	logic [7:0]                color       = '0;
	logic signed [DEPTH_W-1:0] clear_depth = '0;
	logic [12:0]               pixel_index = '0;
	logic                      done;
	logic [2:0]                status;
	logic [12:0]               pixel_out;
	logic [7:0]                read_glyph;
	logic [7:0]                read_color;
	logic                      cfg_valid   = 1'b0;
	logic                      cfg_ready;
	logic [2:0]                cfg_index   = '0;
	logic [19:0]               cfg_data    = '0;

	// shadow copy of the registers, at their reset values
	logic [7:0]              scr_w_reg  = 8'd128;
	logic [6:0]              scr_h_reg  = 7'd64;
	logic [15:0]             aspect_reg = 16'd4096;
	logic signed [POS_W-1:0] cam_x_reg  = '0;
	logic signed [POS_W-1:0] cam_y_reg  = '0;
	logic signed [POS_W-1:0] cam_z_reg  = '0;

	// shadow framebuffer: color in the high byte, glyph in the low byte
	logic [15:0]               cell_mem  [PIX_COUNT];
	logic signed [DEPTH_W-1:0] depth_mem [PIX_COUNT];

	// results predicted at acceptance, oldest first
	pixel_result_t pending_results[$];
	int unsigned   mismatch_count = 0;
	bit            no_idle        = 1'b0;

	zbuffer_point_plotter_top i_dut (
		.clk,
		.arst_n,
		.start,
		.busy,
		.kind,
		.pos_x,
		.pos_y,
		.pos_z,
		.depth_bias,
		.glyph,
		.color,
		.clear_depth,
		.pixel_index,
		.done,
		.status,
		.pixel_out,
		.read_glyph,
		.read_color,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog: far beyond the slowest legal run of this stimulus
	initial begin
		#20_000_000;
		$display("zbuffer_point_plotter_top: mismatch");
		$finish;
	end

	// register values beyond the store act as the maximum
	function automatic int unsigned active_width();
		return (scr_w_reg > MAX_WIDTH) ? MAX_WIDTH : scr_w_reg;
	endfunction

	function automatic int unsigned active_height();
		return (scr_h_reg > MAX_HEIGHT) ? MAX_HEIGHT : scr_h_reg;
	endfunction

	// computes the result of one item and updates the shadow framebuffer
	function automatic pixel_result_t plot_predict(input plot_item_t it);
		pixel_result_t r;
		int unsigned   w, h, off, i;
		longint        dx, dy, dz, depth, nx, ny, col, row;
		r = '{status: ST_READ, pixel: '0, glyph: '0, color: '0};
		w = active_width();
		h = active_height();
		if (it.kind == KIND_CLEAR) begin
			// clear reports pixel 0 and touches only the active area
			for (i = 0; i < w * h; i++) begin
				cell_mem[i]  = {it.color, it.glyph};
				depth_mem[i] = it.clear_depth;
			end
			r.status = ST_CLEARED;
		end else if (it.kind == KIND_POINT) begin
			dx = longint'(it.pos_x) - longint'(cam_x_reg);
			dy = longint'(it.pos_y) - longint'(cam_y_reg);
			dz = longint'(it.pos_z) - longint'(cam_z_reg);
			if (dz < 0) begin
				r.status = ST_BEHIND;
			end else begin
				depth = dz + longint'(it.depth_bias);
				// exact size*(c/2+1/2) with truncation, no rounding in between
				nx    = longint'(w) * (dx + HALF_COL);
				ny    = longint'(h) * (dy * longint'(aspect_reg) + HALF_ROW);
				col   = nx >>> COL_SHIFT;
				row   = ny >>> ROW_SHIFT;
				if (nx < 0 || ny < 0 || col >= longint'(w) || row >= longint'(h)) begin
					r.status = ST_OFF;
				end else begin
					off     = 32'(row * longint'(w) + col);
					r.pixel = off[12:0];
					// less-or-equal wins
					if (depth <= longint'(depth_mem[off])) begin
						depth_mem[off] = depth[DEPTH_W-1:0];
						cell_mem[off]  = {it.color, it.glyph};
						r.status       = ST_DRAWN;
					end else begin
						r.status = ST_HIDDEN;
					end
				end
			end
		end else begin
			r.pixel            = it.pixel_index;
			{r.color, r.glyph} = cell_mem[it.pixel_index];
		end
		return r;
	endfunction

	// every field random; callers narrow what matters
	function automatic plot_item_t noise_item(input logic [1:0] k);
		plot_item_t it;
		it.kind        = k;
		it.pos_x       = POS_W'($urandom);
		it.pos_y       = POS_W'($urandom);
		it.pos_z       = POS_W'($urandom);
		it.depth_bias  = POS_W'($urandom);
		it.glyph       = 8'($urandom);
		it.color       = 8'($urandom);
		it.clear_depth = DEPTH_W'($urandom);
		it.pixel_index = 13'($urandom);
		return it;
	endfunction

	// point in front of the camera that lands on screen, in a narrow depth band
	function automatic plot_item_t aimed_point();
		plot_item_t it;
		int         span, d;
		it       = noise_item(KIND_POINT);
		d        = $urandom_range(0, 8191);
		it.pos_x = cam_x_reg + POS_W'(d - 4096);
		// dy range that keeps the row inside the screen for this aspect
		span = (aspect_reg == 0) ? (1 << 19) : (1 << 24) / aspect_reg;
		if (span > (1 << 19))
			span = 1 << 19;
		d             = $urandom_range(0, 2 * span - 1);
		it.pos_y      = cam_y_reg + POS_W'(d - span);
		d             = $urandom_range(0, 63);
		it.pos_z      = cam_z_reg + POS_W'(d);
		d             = $urandom_range(0, 63);
		it.depth_bias = POS_W'(d - 32);
		return it;
	endfunction

	// behind the camera, just past a side edge, or unconstrained
	function automatic plot_item_t stray_point();
		plot_item_t it;
		it = aimed_point();
		case ($urandom_range(0, 3))
			0: it.pos_z = cam_z_reg - POS_W'($urandom_range(1, 4096));
			1: it.pos_x = cam_x_reg + POS_W'(4096 + $urandom_range(0, 2047));
			2: it.pos_x = cam_x_reg - POS_W'(4097 + $urandom_range(0, 2047));
			default: it = noise_item(KIND_POINT);
		endcase
		return it;
	endfunction

	// mostly aimed points, some strays, reads, and clears kept rare on big screens
	function automatic plot_item_t random_item();
		plot_item_t  it;
		int unsigned area, pick;
		area = active_width() * active_height();
		pick = $urandom_range(0, 127);
		if (pick < ((area > 1024) ? 2 : 5)) begin
			it = noise_item(KIND_CLEAR);
			if ($urandom_range(0, 3) != 0)
				it.clear_depth = DEPTH_W'(int'($urandom_range(0, 127)) - 32);
		end else if (pick < 84) begin
			it = aimed_point();
		end else if (pick < 96) begin
			it = stray_point();
		end else begin
			it = noise_item(($urandom_range(0, 1) != 0) ? KIND_READ : KIND_SPARE);
			if (area != 0 && pick < 120)
				it.pixel_index = 13'($urandom_range(0, area - 1));
		end
		return it;
	endfunction

	// mostly back-to-back or short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned p;
		if (no_idle)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// start stays high across back-to-back items, so it is only lowered for a gap
	task automatic send_item(input plot_item_t it);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		kind        <= it.kind;
		pos_x       <= it.pos_x;
		pos_y       <= it.pos_y;
		pos_z       <= it.pos_z;
		depth_bias  <= it.depth_bias;
		glyph       <= it.glyph;
		color       <= it.color;
		clear_depth <= it.clear_depth;
		pixel_index <= it.pixel_index;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		// accepted at this edge
		pending_results.push_back(plot_predict(it));
	endtask

	// hold the item channel until every predicted result has come back
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
		repeat ($urandom_range(0, 3)) @(posedge clk);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_WIDTH:  scr_w_reg  = val[7:0];
			CFG_HEIGHT: scr_h_reg  = val[6:0];
			CFG_ASPECT: aspect_reg = val[15:0];
			CFG_CAM_X:  cam_x_reg  = val;
			CFG_CAM_Y:  cam_y_reg  = val;
			CFG_CAM_Z:  cam_z_reg  = val;
			default: ;
		endcase
	endtask

	task automatic set_screen(input logic [19:0] w, h, a, cx, cy, cz);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		write_reg(CFG_ASPECT, a);
		write_reg(CFG_CAM_X, cx);
		write_reg(CFG_CAM_Y, cy);
		write_reg(CFG_CAM_Z, cz);
	endtask

	task automatic send_point(input logic signed [POS_W-1:0] x, y, z, b);
		plot_item_t it;
		it            = noise_item(KIND_POINT);
		it.pos_x      = x;
		it.pos_y      = y;
		it.pos_z      = z;
		it.depth_bias = b;
		send_item(it);
	endtask

	task automatic send_clear(input logic [7:0] g, c, input logic signed [DEPTH_W-1:0] d);
		plot_item_t it;
		it             = noise_item(KIND_CLEAR);
		it.glyph       = g;
		it.color       = c;
		it.clear_depth = d;
		send_item(it);
	endtask

	task automatic send_read(input logic [1:0] k, input logic [12:0] idx);
		plot_item_t it;
		it             = noise_item(k);
		it.pixel_index = idx;
		send_item(it);
	endtask

	// framebuffer is zero after reset; the unused kind reads too
	task automatic test_reset_contents();
		send_read(KIND_READ, '0);
		send_read(KIND_SPARE, '1);
	endtask

	// full clear to the deepest depth, then draw, lose and tie at the center
	task automatic test_depth_order();
		send_clear(8'hFF, 8'h00, {1'b0, {(DEPTH_W-1){1'b1}}});
		send_point(0, 0, 5, 0);
		send_point(0, 0, 9, 0);
		send_point(0, 0, 2, 3);
		send_read(KIND_READ, 13'(32 * MAX_WIDTH + 64));
	endtask

	// behind the camera, each screen edge, and the field extremes
	task automatic test_culling();
		send_point(0, 0, -1, 0);
		send_point(4096, 0, 0, 0);
		send_point(-4097, 0, 0, 0);
		send_point(0, 4096, 0, 0);
		send_point(0, -4097, 0, 0);
		send_point(-524288, 524287, 524287, -524288);
		send_point(524287, -524288, -524288, 524287);
		send_point(0, 0, 524287, -524288);
	endtask

	// first and last pixel of the full screen
	task automatic test_corners();
		send_point(-4096, -4096, 0, 0);
		send_point(4095, 4095, 1, 0);
		send_read(KIND_READ, 13'(PIX_COUNT - 1));
	endtask

	// clear to the shallowest depth: even the nearest point is hidden
	task automatic test_clear_extremes();
		send_clear(8'h00, 8'hFF, {1'b1, {(DEPTH_W-1){1'b0}}});
		send_point(0, 0, 0, -524288);
		send_read(KIND_SPARE, '0);
	endtask

	// zero width clears nothing and culls all; oversized sizes clamp to the store
	task automatic test_screen_limits();
		wait_idle();
		set_screen(20'd0, 20'd1, 20'd4096, '0, '0, '0);
		send_clear(8'h5A, 8'hA5, '0);
		send_point(0, 0, 0, 0);
		wait_idle();
		set_screen(20'd255, 20'd127, 20'd65535, '0, '0, '0);
		send_clear(8'h3C, 8'hC3, 22'sd100);
		send_point(4095, 255, 0, 0);
	endtask

	// phases of random items, each under its own register setting
	task automatic test_random_phases();
		int unsigned phase, n;
		for (phase = 0; phase < PHASES; phase++) begin
			// registers only change with nothing in flight
			wait_idle();
			case (phase)
				0: set_screen(20'd1, 20'd1, 20'd4096, '0, '0, '0);
				1: set_screen(20'd128, 20'd64, 20'd4096, '0, '0, '0);
				2: set_screen(20'd255, 20'd127, 20'd65535, 20'h80000, 20'h7FFFF, 20'h80000);
				3: set_screen($urandom_range(1, 16), $urandom_range(1, 8), 20'd0,
					20'h7FFFF, 20'h80000, 20'h7FFFF);
				default: set_screen($urandom_range(1, 24), $urandom_range(1, 16),
					$urandom_range(0, 65535), 20'($urandom), 20'($urandom), 20'($urandom));
			endcase
			no_idle = (phase % 3 == 2);
			for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
				// stretches with and without idling, and an occasional full drain
				if ($urandom_range(0, 49) == 0)
					no_idle = !no_idle;
				if ($urandom_range(0, 199) == 0)
					wait_idle();
				send_item(random_item());
			end
		end
	endtask

	// done is a one-cycle strobe: compare each result with the oldest prediction
	always @(posedge clk) begin : result_check
		pixel_result_t got, want;
		if (arst_n && done === 1'b1) begin
			got = '{status: status_t'(status), pixel: pixel_out,
				glyph: read_glyph, color: read_color};
			if (pending_results.size() == 0) begin
				if (mismatch_count < MAX_REPORTS)
					$display("unexpected result: status %0d pixel %0d glyph %h color %h",
						got.status, got.pixel, got.glyph, got.color);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					if (mismatch_count < MAX_REPORTS)
						$display("result differs: expected status %0d pixel %0d glyph %h color %h, got status %0d pixel %0d glyph %h color %h",
							want.status, want.pixel, want.glyph, want.color,
							got.status, got.pixel, got.glyph, got.color);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		int i;
		for (i = 0; i < PIX_COUNT; i++) begin
			cell_mem[i]  = '0;
			depth_mem[i] = '0;
		end
		// single reset; the block then runs its clearing pass with busy high
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_contents();
		test_depth_order();
		test_culling();
		test_corners();
		test_clear_extremes();
		test_screen_limits();
		test_random_phases();
		wait_idle();
		// catch any stray result after the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("zbuffer_point_plotter_top: match");
		else
			$display("zbuffer_point_plotter_top: mismatch");
		$finish;
	end

endmodule

>>> sim.f
design/zbp_pkg.sv
design/zbp_mem.sv
design/zbp_map.sv
design/zbuffer_point_plotter_top.sv
verif/zbuffer_point_plotter_tb.sv
